[hdl/csvrs_pkg.sv]
// Shared types, codes and character constants of the CSV record splitter.
// Has no dependencies; every other file of the block refers to it by scoped name.
`default_nettype none

package csvrs_pkg;

   // Internal counter widths.
   localparam int OFFSET_BITS     = 32;
   localparam int LENGTH_BITS     = 24;
   // Widths of the fields on the ports.
   localparam int OUT_OFFSET_BITS = 32;
   localparam int OUT_LENGTH_BITS = 24;
   localparam int MAXLEN_BITS     = 24;
   localparam int CMP_BITS        = (LENGTH_BITS > MAXLEN_BITS) ? LENGTH_BITS : MAXLEN_BITS;

   typedef logic [OFFSET_BITS-1:0]     offset_type;
   typedef logic [LENGTH_BITS-1:0]     length_type;
   typedef logic [OUT_OFFSET_BITS-1:0] out_offset_type;
   typedef logic [OUT_LENGTH_BITS-1:0] out_length_type;
   typedef logic [MAXLEN_BITS-1:0]     maxlen_type;
   typedef logic [CMP_BITS-1:0]        cmp_type;

   localparam length_type LENGTH_MAX = '1;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef enum logic {
      FUNC_DATA = 1'b0,
      FUNC_END  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_TOO_LONG   = 2'd1,
      STATUS_OPEN_QUOTE = 2'd2
   } status_type;

   typedef enum logic {
      REG_ESCAPE_BYTE       = 1'b0,
      REG_MAX_RECORD_LENGTH = 1'b1
   } reg_index_type;

   localparam logic [7:0] ESCAPE_RESET  = 8'h00;
   localparam maxlen_type MAXLEN_RESET  = '1;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] escape_byte;
      maxlen_type max_record_length;
   } cfg_type;

   typedef struct packed {
      out_offset_type record_offset;
      out_length_type record_length;
      logic [1:0]     status;
      out_offset_type quote_offset;
      logic           at_end;
   } result_type;

endpackage

`default_nettype wire

[hdl/csvrs_if.sv]
// Channel interfaces of the CSV record splitter: request, result and register write.
// Depends on csvrs_pkg for the field widths.
`default_nettype none

interface csvrs_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface csvrs_rsp_if;
   logic                      valid;
   logic                      ready;
   csvrs_pkg::out_offset_type record_offset;
   csvrs_pkg::out_length_type record_length;
   logic [1:0]                status;
   csvrs_pkg::out_offset_type quote_offset;
   logic                      at_end;

   modport source (output valid, output record_offset, output record_length,
                   output status, output quote_offset, output at_end, input ready);
   modport sink   (input valid, input record_offset, input record_length,
                   input status, input quote_offset, input at_end, output ready);
endinterface

interface csvrs_csr_if;
   logic                  valid;
   logic                  ready;
   logic                  index;
   csvrs_pkg::maxlen_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/csvrs_csr_regs.sv]
// Configuration registers of the CSV record splitter: escape byte and length limit.
// Depends on csvrs_pkg and the csvrs_csr_if interface.
`default_nettype none

module csvrs_csr_regs (
   input  wire logic        clock,
   input  wire logic        reset,
   csvrs_csr_if.sink        csr_if,
   output csvrs_pkg::cfg_type cfg
);

   logic [7:0]            escape_ff, escape_in;
   csvrs_pkg::maxlen_type maxlen_ff, maxlen_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      escape_in = escape_ff;
      maxlen_in = maxlen_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            csvrs_pkg::REG_ESCAPE_BYTE:       escape_in = csr_if.data[7:0];
            csvrs_pkg::REG_MAX_RECORD_LENGTH: maxlen_in = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= csvrs_pkg::ESCAPE_RESET;
         maxlen_ff <= csvrs_pkg::MAXLEN_RESET;
      end else begin
         escape_ff <= escape_in;
         maxlen_ff <= maxlen_in;
      end
   end

   assign cfg.escape_byte       = escape_ff;
   assign cfg.max_record_length = maxlen_ff;

endmodule

`default_nettype wire

[hdl/csvrs_scanner.sv]
// Per-byte scanner of the CSV record splitter: quote, escape and line-break state
// and the record result that an item causes. Depends on csvrs_pkg.
`default_nettype none

module csvrs_scanner (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire csvrs_pkg::item_type item,
   input  wire csvrs_pkg::cfg_type  cfg,
   output logic                  has_result,
   output csvrs_pkg::result_type result
);

   csvrs_pkg::offset_type pos_ff, pos_in;
   csvrs_pkg::offset_type begin_ff, begin_in;
   csvrs_pkg::offset_type open_ff, open_in;
   csvrs_pkg::length_type len_ff, len_in;
   logic inq_ff, inq_in;
   logic qsp_ff, qsp_in;
   logic esc_ff, esc_in;
   logic lfs_ff, lfs_in;
   logic cr_ff, cr_in;

   logic                  emit_open;
   logic                  done;
   logic [7:0]            b;
   csvrs_pkg::offset_type pos_next;
   csvrs_pkg::length_type len_count;
   csvrs_pkg::length_type rep_len;
   csvrs_pkg::status_type status;

   assign b         = item.data_byte;
   assign pos_next  = pos_ff + csvrs_pkg::offset_type'(1);
   assign len_count = (len_ff == csvrs_pkg::LENGTH_MAX) ? len_ff
                                                        : len_ff + csvrs_pkg::length_type'(1);

   // Result fields come from the state before the item is applied.
   always_comb begin
      rep_len = (cr_ff && len_ff != '0) ? len_ff - csvrs_pkg::length_type'(1) : len_ff;
      if (emit_open)
         status = csvrs_pkg::STATUS_OPEN_QUOTE;
      else if (len_ff == csvrs_pkg::LENGTH_MAX ||
               csvrs_pkg::cmp_type'(rep_len) > csvrs_pkg::cmp_type'(cfg.max_record_length))
         status = csvrs_pkg::STATUS_TOO_LONG;
      else
         status = csvrs_pkg::STATUS_OK;
      result.record_offset = csvrs_pkg::out_offset_type'(begin_ff);
      result.record_length = csvrs_pkg::out_length_type'(rep_len);
      result.status        = status;
      result.quote_offset  = (status == csvrs_pkg::STATUS_OPEN_QUOTE) ?
                             csvrs_pkg::out_offset_type'(open_ff) : '0;
      result.at_end        = (item.func == csvrs_pkg::FUNC_END);
   end

   always_comb begin
      pos_in     = pos_ff;
      begin_in   = begin_ff;
      open_in    = open_ff;
      len_in     = len_ff;
      inq_in     = inq_ff;
      qsp_in     = qsp_ff;
      esc_in     = esc_ff;
      lfs_in     = lfs_ff;
      cr_in      = cr_ff;
      has_result = 1'b0;
      emit_open  = 1'b0;
      done       = 1'b0;

      if (item.func == csvrs_pkg::FUNC_END) begin
         if (inq_ff) begin
            has_result = 1'b1;
            emit_open  = 1'b1;
         end else if (pos_ff != begin_ff) begin
            has_result = 1'b1;
         end
         pos_in   = '0;
         begin_in = '0;
         open_in  = '0;
         len_in   = '0;
         inq_in   = 1'b0;
         qsp_in   = 1'b0;
         esc_in   = 1'b0;
         lfs_in   = 1'b0;
         cr_in    = 1'b0;
      end else begin
         pos_in = pos_next;

         // An LF straight after a CR terminator belongs to that terminator.
         if (lfs_ff) begin
            lfs_in = 1'b0;
            if (b == csvrs_pkg::CHAR_LF) begin
               begin_in = pos_next;
               done     = 1'b1;
            end
         end

         // Inside quotes the escape check comes before everything else.
         if (!done && inq_ff && cfg.escape_byte != csvrs_pkg::CHAR_NUL) begin
            if (esc_ff) begin
               esc_in = 1'b0;
               len_in = len_count;
               cr_in  = (b == csvrs_pkg::CHAR_CR);
               done   = 1'b1;
            end else if (b == cfg.escape_byte) begin
               esc_in = 1'b1;
               len_in = len_count;
               cr_in  = (b == csvrs_pkg::CHAR_CR);
               done   = 1'b1;
            end
         end

         if (!done && b == csvrs_pkg::CHAR_QUOTE) begin
            if (inq_ff) begin
               inq_in = 1'b0;
               qsp_in = 1'b1;
            end else if (qsp_ff) begin
               inq_in = 1'b1;
               qsp_in = 1'b0;
            end else begin
               inq_in  = 1'b1;
               open_in = pos_ff;
            end
            len_in = len_count;
            cr_in  = 1'b0;
            done   = 1'b1;
         end

         if (!done) begin
            qsp_in = 1'b0;
            if (!inq_ff && (b == csvrs_pkg::CHAR_LF || b == csvrs_pkg::CHAR_CR)) begin
               has_result = 1'b1;
               begin_in   = pos_next;
               len_in     = '0;
               cr_in      = 1'b0;
               esc_in     = 1'b0;
               lfs_in     = (b == csvrs_pkg::CHAR_CR);
            end else begin
               len_in = len_count;
               cr_in  = (b == csvrs_pkg::CHAR_CR);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         begin_ff <= '0;
         open_ff  <= '0;
         len_ff   <= '0;
         inq_ff   <= 1'b0;
         qsp_ff   <= 1'b0;
         esc_ff   <= 1'b0;
         lfs_ff   <= 1'b0;
         cr_ff    <= 1'b0;
      end else if (step) begin
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         open_ff  <= open_in;
         len_ff   <= len_in;
         inq_ff   <= inq_in;
         qsp_ff   <= qsp_in;
         esc_ff   <= esc_in;
         lfs_ff   <= lfs_in;
         cr_ff    <= cr_in;
      end
   end

endmodule

`default_nettype wire

[hdl/csvrs_result_reg.sv]
// Result register of the CSV record splitter, driving the result channel.
// Depends on csvrs_pkg and the csvrs_rsp_if interface.
`default_nettype none

module csvrs_result_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire csvrs_pkg::result_type result,
   output logic                  free,
   csvrs_rsp_if.source           rsp_if
);

   logic                  valid_ff, valid_in;
   csvrs_pkg::result_type data_ff;

   assign free     = !valid_ff || rsp_if.ready;
   assign valid_in = load || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load)
         data_ff <= result;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.record_offset = data_ff.record_offset;
   assign rsp_if.record_length = data_ff.record_length;
   assign rsp_if.status        = data_ff.status;
   assign rsp_if.quote_offset  = data_ff.quote_offset;
   assign rsp_if.at_end        = data_ff.at_end;

endmodule

`default_nettype wire

[hdl/csv_record_splitter_core.sv]
// Top level of the CSV record splitter: input register, scanner, result register
// and configuration registers. Depends on csvrs_pkg, the csvrs interfaces and submodules.
`default_nettype none

// The splitter takes a CSV stream one byte per item, followed by an end-of-input
// item, and returns one item for every record it finds. It accepts one item in
// every clock cycle: each item is held in the input register, the scanner
// applies it to the quote and line-break state from there, and any result it
// causes is written to the result register, which drives the result channel.
// The only thing that slows acceptance is back-pressure on the result channel:
// while a result waits untaken, the input register holds one further item and
// then stalls. The scanner only moves while the result register is free, so
// items that cause no result are held back in the same way. There is no clearing
// pass after reset. The end-of-input item returns all stream state to its reset
// values, so the next byte is at offset zero; the escape byte and length limit
// are kept.

module csv_record_splitter_core (
   input  wire logic   clock,
   input  wire logic   reset,
   csvrs_req_if.sink   req_if,
   csvrs_rsp_if.source rsp_if,
   csvrs_csr_if.sink   csr_if
);

   csvrs_pkg::cfg_type    cfg;
   csvrs_pkg::result_type result;
   logic                  has_result;
   logic                  out_free;
   logic                  advance;

   // Input register: one item held until the scanner can apply it.
   logic                in_valid_ff, in_valid_in;
   csvrs_pkg::item_type in_item_ff;
   logic                accept;

   // The scanner moves only when a result, if any, has somewhere to go.
   assign advance      = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;
   assign in_valid_in  = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.func      <= req_if.func;
         in_item_ff.data_byte <= req_if.data_byte;
      end
   end

   csvrs_csr_regs u_csr_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   csvrs_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (result)
   );

   csvrs_result_reg u_result_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && has_result),
      .result (result),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

   // An open quote can only be reported by the end-of-input item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status == csvrs_pkg::STATUS_OPEN_QUOTE |-> rsp_if.at_end)
      else $error("open quote status on a result not caused by end of input");

   // The quote offset is only filled in for an open quote.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status != csvrs_pkg::STATUS_OPEN_QUOTE |->
         rsp_if.quote_offset == '0)
      else $error("quote offset set on a result without open quote status");

   // A record reported as ok never exceeds the configured limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status == csvrs_pkg::STATUS_OK |->
         rsp_if.record_length <= cfg.max_record_length)
      else $error("ok record longer than the configured limit");

   // A held item that can move on is consumed, so the input register frees up.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_free && !req_if.valid |=> !in_valid_ff)
      else $error("input register kept an item that the scanner took");

endmodule

`default_nettype wire
